>>> hdl/assert_macros.svh
// Assertion macros shared by the staircase search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, disabled while arst_n is low.
`define SMSS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never hold.
`define SMSS_ASSERT_NEVER(lbl, cond, msg) \
	`SMSS_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/smss_pkg.sv
// Package: sizes, codes and shared types of the staircase search block.
package smss_pkg;

	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int DATA_WIDTH = 32;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;

	localparam int CFG_W     = 5;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [CFG_W-1:0] RESET_ROWS = CFG_W'(MAX_ROWS);
	localparam logic [CFG_W-1:0] RESET_COLS = CFG_W'(MAX_COLS);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ROWS_IN_USE = 1'b0,
		REG_COLS_IN_USE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		KIND_WRITE  = 1'b0,
		KIND_SEARCH = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} walk_state_t;

	typedef struct packed {
		logic [CFG_W-1:0] rows_in_use;
		logic [CFG_W-1:0] cols_in_use;
	} cfg_t;

	typedef struct packed {
		logic                  we;
		logic [ADDR_W-1:0]     waddr;
		logic [DATA_WIDTH-1:0] wdata;
		logic                  re;
		logic [ADDR_W-1:0]     raddr;
	} mem_req_t;

endpackage

>>> hdl/sorted_matrix_staircase_search.sv
// Write transaction: stored at the accepting edge, no result. Search: one store read per cycle,
// k reads with k <= rows + columns - 1; the result is registered when the walk hits or misses
// (at the accepting edge for an empty region), and the next transaction is taken once the walk is idle.
// The walk is paced by the single store read port.
// Reset: region 16 rows by 16 columns, walk idle, no result pending.
// Matrix contents are undefined until written; there is no clearing pass.
module sorted_matrix_staircase_search import smss_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [PADDR_W-1:0]           paddr,
	input  logic [PDATA_W-1:0]           pwdata,
	output logic [PDATA_W-1:0]           prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [ROW_W-1:0]             row_index,
	input  logic [COL_W-1:0]             col_index,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [ROW_W-1:0]             found_row,
	output logic [COL_W-1:0]             found_col
);

	cfg_t                  cfg;
	mem_req_t              mem_req;
	logic [DATA_WIDTH-1:0] rd_data;

	smss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smss_mem u_mem (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	smss_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.found_row (found_row),
		.found_col (found_col)
	);

endmodule

>>> hdl/smss_regs.sv
// APB configuration registers: rows and columns of the searched region.
module smss_regs import smss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	reg_idx_t         idx;
	logic             wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RESET_ROWS;
			cols_q <= RESET_COLS;
		end else if (wr_en) begin
			case (idx)
				REG_ROWS_IN_USE: rows_q <= pwdata[CFG_W-1:0];
				REG_COLS_IN_USE: cols_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ROWS_IN_USE: prdata = PDATA_W'(rows_q);
			REG_COLS_IN_USE: prdata = PDATA_W'(cols_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.rows_in_use = rows_q;
	assign cfg.cols_in_use = cols_q;

endmodule

>>> hdl/smss_mem.sv
// Matrix store: one write port, one registered read port.
module smss_mem import smss_pkg::*; (
	input  logic                  clk,
	input  mem_req_t              mem_req,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem_q[mem_req.waddr] <= mem_req.wdata;
		end
		if (mem_req.re) begin
			rd_data_q <= mem_q[mem_req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/smss_walk.sv
// Staircase walk sequencer with the shared signed comparator and result register.
`include "assert_macros.svh"

module smss_walk import smss_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         kind,
	input  logic [ROW_W-1:0]             row_index,
	input  logic [COL_W-1:0]             col_index,
	input  logic signed [DATA_WIDTH-1:0] value,
	output mem_req_t                     mem_req,
	input  logic [DATA_WIDTH-1:0]        rd_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [ROW_W-1:0]             found_row,
	output logic [COL_W-1:0]             found_col
);

	walk_state_t                  st_q;
	logic [CFG_W-1:0]             x_q;
	logic [CFG_W-1:0]             y_q;
	logic signed [DATA_WIDTH-1:0] key_q;
	logic                         out_valid_q;
	logic                         found_q;
	logic [ROW_W-1:0]             found_row_q;
	logic [COL_W-1:0]             found_col_q;

	logic [CFG_W-1:0]             rows_eff;
	logic [CFG_W-1:0]             cols_eff;
	logic [CFG_W-1:0]             cols_m1;
	logic                         accept;
	logic                         start;
	logic                         empty;
	logic                         walking;
	logic signed [DATA_WIDTH-1:0] elem;
	logic                         lt;
	logic                         gt;
	logic                         hit;
	logic                         miss;
	logic                         step;
	logic [CFG_W-1:0]             nx;
	logic [CFG_W-1:0]             ny;
	logic [CFG_W-1:0]             ny_m1;
	logic [CFG_W-1:0]             y_m1;

	assign rows_eff = (cfg.rows_in_use > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : cfg.rows_in_use;
	assign cols_eff = (cfg.cols_in_use > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cfg.cols_in_use;
	assign cols_m1  = cols_eff - CFG_W'(1);
	assign empty    = (rows_eff == '0) || (cols_eff == '0);

	// a search needs the result slot free (or emptying) before it starts
	assign in_ready = (st_q == ST_IDLE) &&
		((kind == KIND_WRITE) || !out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign start    = accept && (kind == KIND_SEARCH);
	assign walking  = (st_q == ST_WALK);

	assign elem  = rd_data;
	assign lt    = key_q < elem;
	assign gt    = key_q > elem;
	assign nx    = x_q + CFG_W'(gt);
	assign ny    = y_q - CFG_W'(lt);
	assign ny_m1 = ny - CFG_W'(1);
	assign y_m1  = y_q - CFG_W'(1);
	assign hit   = walking && !lt && !gt;
	assign miss  = walking && !hit && ((nx >= rows_eff) || (ny == '0));
	assign step  = walking && !hit && !miss;

	always_comb begin
		mem_req.we    = accept && (kind == KIND_WRITE);
		mem_req.waddr = {row_index, col_index};
		mem_req.wdata = value;
		mem_req.re    = (start && !empty) || step;
		if (walking) begin
			mem_req.raddr = {nx[ROW_W-1:0], ny_m1[COL_W-1:0]};
		end else begin
			mem_req.raddr = {ROW_W'(0), cols_m1[COL_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: if (start && !empty) st_q <= ST_WALK;
				ST_WALK: if (hit || miss) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= value;
			x_q   <= '0;
			y_q   <= cols_eff;
		end else if (step) begin
			x_q <= nx;
			y_q <= ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((start && empty) || hit || miss) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((start && empty) || hit || miss) begin
			found_q     <= hit;
			found_row_q <= hit ? x_q[ROW_W-1:0] : '0;
			found_col_q <= hit ? y_m1[COL_W-1:0] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign found_row = found_row_q;
	assign found_col = found_col_q;

	`SMSS_ASSERT(a_walk_has_data, walking |-> $past(mem_req.re), "walk step without a read")
	`SMSS_ASSERT_NEVER(a_no_write_in_walk, walking && mem_req.we, "store written during walk")
	`SMSS_ASSERT(a_walk_in_region, walking |-> (x_q < rows_eff) && (y_q != '0),
		"walk left the region")
	`SMSS_ASSERT(a_hit_in_region, out_valid_q && found_q |->
		(CFG_W'(found_row_q) < rows_eff) && (CFG_W'(found_col_q) < cols_eff),
		"hit outside the region")

endmodule
